// ===== rtl/core/swtmr_pkg.sv =====
// Shared types and codes for the timer task table.
`timescale 1ns / 1ps

package swtmr_pkg;

  // Request modes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_ONCE     = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;
  localparam logic [1:0] MODE_DETACH   = 2'd3;

  // Result codes
  localparam logic [2:0] EV_FIRED    = 3'd0;
  localparam logic [2:0] EV_ATTACHED = 3'd1;
  localparam logic [2:0] EV_FULL     = 3'd2;
  localparam logic [2:0] EV_MARKED   = 3'd3;
  localparam logic [2:0] EV_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [7:0]  task_id;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] task_ref;
    logic       last;
  } rsp_t;

  // Controller to datapath commands
  typedef logic [2:0] dp_cmd_t;
  localparam dp_cmd_t CMD_NONE      = 3'd0;
  localparam dp_cmd_t CMD_LOAD      = 3'd1;
  localparam dp_cmd_t CMD_READ      = 3'd2;
  localparam dp_cmd_t CMD_TICK_EVAL = 3'd3;
  localparam dp_cmd_t CMD_DET_EVAL  = 3'd4;
  localparam dp_cmd_t CMD_ATTACH    = 3'd5;
  localparam dp_cmd_t CMD_DET_MISS  = 3'd6;
  localparam dp_cmd_t CMD_FLUSH     = 3'd7;

  typedef struct packed {
    logic [1:0] mode;      // mode of the request in progress
    logic       walk_end;  // read pointer has reached the fill count
    logic       hit;       // entry just read carries the requested id
  } dp_status_t;

endpackage

// ===== rtl/core/swtmr_ctrl.sv =====
// Sequencer for attach, detach search and tick walk.
`timescale 1ns / 1ps

module swtmr_ctrl
  import swtmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_EVAL   = 2'd2;
  localparam logic [1:0] ST_ATTACH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd = CMD_LOAD;
          if (mode == MODE_TICK || mode == MODE_DETACH) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_ATTACH;
          end
        end
      end
      ST_WALK: begin
        if (status.walk_end) begin
          cmd        = (status.mode == MODE_TICK) ? CMD_FLUSH : CMD_DET_MISS;
          state_next = ST_IDLE;
        end else begin
          cmd        = CMD_READ;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.mode == MODE_TICK) begin
          cmd        = CMD_TICK_EVAL;
          state_next = ST_WALK;
        end else begin
          cmd        = CMD_DET_EVAL;
          state_next = status.hit ? ST_IDLE : ST_WALK;
        end
      end
      ST_ATTACH: begin
        cmd        = CMD_ATTACH;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/core/swtmr_dp.sv =====
// Task table memory, pointers, fire holding register and result register.
`timescale 1ns / 1ps

module swtmr_dp
  import swtmr_pkg::*;
#(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output rsp_t       rsp,
  output logic       strobe
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic               once;
    logic               marked;
    logic [ID_BITS-1:0] id;
    logic [31:0]        interval;
    logic [31:0]        stamp;
  } entry_t;

  entry_t mem [SLOTS];

  logic [1:0]         cmd_mode;
  logic [31:0]        cmd_now;
  logic [31:0]        cmd_ivl;
  logic [ID_BITS-1:0] cmd_id;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rptr;
  logic [CW-1:0]      wptr;
  entry_t             rd_data;
  logic               pend_valid;
  logic [ID_BITS-1:0] pend_id;

  logic               we;
  logic [AW-1:0]      wa;
  entry_t             wd;
  logic               due;
  logic               full;

  assign due  = (cmd_now - rd_data.stamp) >= rd_data.interval;
  assign full = (count == CW'(SLOTS));

  assign status.mode     = cmd_mode;
  assign status.walk_end = (rptr == count);
  assign status.hit      = (rd_data.id == cmd_id);

  // Single write port: compaction writes land at wptr, which never passes rptr
  always_comb begin
    we = 1'b0;
    wa = rptr[AW-1:0];
    wd = rd_data;
    case (cmd)
      CMD_TICK_EVAL: begin
        wa = wptr[AW-1:0];
        if (due) begin
          wd.stamp = cmd_now;
        end
        we = !rd_data.marked && !(due && rd_data.once);
      end
      CMD_DET_EVAL: begin
        wd.marked = 1'b1;
        we        = status.hit;
      end
      CMD_ATTACH: begin
        wa          = count[AW-1:0];
        wd.once     = (cmd_mode == MODE_ONCE);
        wd.marked   = 1'b0;
        wd.id       = cmd_id;
        wd.interval = cmd_ivl;
        wd.stamp    = cmd_now;
        we          = !full;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd == CMD_READ) begin
      rd_data <= mem[rptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rptr       <= '0;
      wptr       <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (cmd)
        CMD_NONE, CMD_READ: begin
        end
        CMD_LOAD: begin
          cmd_mode   <= req.mode;
          cmd_now    <= req.now_ms;
          cmd_ivl    <= req.interval_ms;
          cmd_id     <= ID_BITS'(req.task_id);
          rptr       <= '0;
          wptr       <= '0;
          pend_valid <= 1'b0;
        end
        CMD_TICK_EVAL: begin
          rptr <= rptr + 1'b1;
          if (!rd_data.marked) begin
            if (due) begin
              // hold each fire until the next one shows it was not the final
              pend_valid <= 1'b1;
              pend_id    <= rd_data.id;
              if (pend_valid) begin
                strobe        <= 1'b1;
                rsp.event_res <= EV_FIRED;
                rsp.task_ref  <= 8'(pend_id);
                rsp.last      <= 1'b0;
              end
            end
            if (!(due && rd_data.once)) begin
              wptr <= wptr + 1'b1;
            end
          end
        end
        CMD_DET_EVAL: begin
          rptr <= rptr + 1'b1;
          if (status.hit) begin
            strobe        <= 1'b1;
            rsp.event_res <= EV_MARKED;
            rsp.task_ref  <= 8'(cmd_id);
            rsp.last      <= 1'b1;
          end
        end
        CMD_ATTACH: begin
          strobe        <= 1'b1;
          rsp.task_ref  <= 8'(cmd_id);
          rsp.last      <= 1'b1;
          if (full) begin
            rsp.event_res <= EV_FULL;
          end else begin
            rsp.event_res <= EV_ATTACHED;
            count         <= count + 1'b1;
          end
        end
        CMD_DET_MISS: begin
          strobe        <= 1'b1;
          rsp.event_res <= EV_NOTFOUND;
          rsp.task_ref  <= 8'(cmd_id);
          rsp.last      <= 1'b1;
        end
        CMD_FLUSH: begin
          count      <= wptr;
          pend_valid <= 1'b0;
          if (pend_valid) begin
            strobe        <= 1'b1;
            rsp.event_res <= EV_FIRED;
            rsp.task_ref  <= 8'(pend_id);
            rsp.last      <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/software_timer_task_table.sv =====
// Top level of the timer task table.
`timescale 1ns / 1ps

// Timer task table. An item is taken when start is high and busy is low; busy
// then stays high until the item's work is done. Results come one per strobe
// cycle and cannot be held off by the receiver. The table memory has one read
// and one write port, and each slot visit is a read step followed by an
// evaluate step. A detach stops at the first matching task; a tick visits
// every task. The final result of an item, if it has one (a tick with no due
// task gives none), appears in the first cycle busy is low again.

module software_timer_task_table
  import swtmr_pkg::*;
#(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic strobe,
  output rsp_t rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  swtmr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (req.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  swtmr_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp),
    .strobe (strobe)
  );

endmodule

// ===== rtl/core/swtmr_chk.sv =====
// Port-level checks for the timer task table, bound to the top level.
`timescale 1ns / 1ps

module swtmr_chk
  import swtmr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transfer");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.last |-> !busy)
    else $error("final result while still busy");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !busy |-> rsp.last)
    else $error("non-final result while idle");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.event_res != EV_FIRED |-> rsp.last)
    else $error("attach or detach result not marked final");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> rsp.event_res <= EV_NOTFOUND)
    else $error("result code out of range");

endmodule

bind software_timer_task_table swtmr_chk u_swtmr_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .rsp    (rsp)
);

// ===== sim/tb.sv =====
// Self-checking bench for the timer task table: attach, detach and tick traffic.
`timescale 1ns / 1ps

module tb;
  import swtmr_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        once;
    logic        marked;
    logic [7:0]  id;
    logic [31:0] interval;
    logic [31:0] stamp;
  } timer_entry_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req   = '0;
  logic strobe;
  rsp_t rsp;

  timer_entry_t timers[$];
  req_t         timer_reqs[$];
  rsp_t         predicted_events[$];

  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned errors         = 0;
  int unsigned mismatches     = 0;
  int unsigned events_checked = 0;
  int unsigned fires_seen     = 0;
  int unsigned full_seen      = 0;
  int unsigned cycles         = 0;
  int unsigned reqs_sent[4]   = '{default: 0};

  software_timer_task_table dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .rsp    (rsp)
  );

  always #5 clk = ~clk;

  // Update the timer list for one request and queue the events it should produce.
  task automatic apply_request(input req_t r);
    timer_entry_t kept[$];
    timer_entry_t e;
    rsp_t         fired[$];
    rsp_t         ev;
    logic [31:0]  elapsed;
    int           hit;
    hit = -1;
    case (r.mode)
      MODE_TICK: begin
        foreach (timers[k]) begin
          e = timers[k];
          if (e.marked) continue;
          elapsed = r.now_ms - e.stamp;
          if (elapsed >= e.interval) begin
            ev.event_res = EV_FIRED;
            ev.task_ref  = e.id;
            ev.last      = 1'b0;
            fired.insert(fired.size(), ev);
            if (e.once) continue;
            e.stamp = r.now_ms;
          end
          kept.insert(kept.size(), e);
        end
        timers = kept;
        if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
        foreach (fired[k]) predicted_events.insert(predicted_events.size(), fired[k]);
      end
      MODE_DETACH: begin
        foreach (timers[k]) begin
          if (hit < 0 && timers[k].id == r.task_id) hit = k;
        end
        if (hit >= 0) timers[hit].marked = 1'b1;
        ev.event_res = (hit >= 0) ? EV_MARKED : EV_NOTFOUND;
        ev.task_ref  = r.task_id;
        ev.last      = 1'b1;
        predicted_events.insert(predicted_events.size(), ev);
      end
      default: begin
        if (timers.size() >= SLOTS) begin
          ev.event_res = EV_FULL;
        end else begin
          e.once     = (r.mode == MODE_ONCE);
          e.marked   = 1'b0;
          e.id       = r.task_id;
          e.interval = r.interval_ms;
          e.stamp    = r.now_ms;
          timers.insert(timers.size(), e);
          ev.event_res = EV_ATTACHED;
        end
        ev.task_ref = r.task_id;
        ev.last     = 1'b1;
        predicted_events.insert(predicted_events.size(), ev);
      end
    endcase
  endtask

  task automatic queue_req(input logic [1:0] mode, input logic [31:0] now_ms,
                           input logic [31:0] interval_ms, input logic [7:0] task_id);
    req_t r;
    r.mode        = mode;
    r.now_ms      = now_ms;
    r.interval_ms = interval_ms;
    r.task_id     = task_id;
    timer_reqs.insert(timer_reqs.size(), r);
  endtask

  // Request driver: bursts of back-to-back requests separated by random gaps.
  always @(posedge clk) begin : drive
    logic go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        apply_request(req);
        reqs_sent[req.mode]++;
        void'(timer_reqs.pop_front());
        go = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (timer_reqs.size() > 0) begin
          go = 1'b1;
          req <= timer_reqs[0];
        end
      end
      start <= go;
    end
  end

  // Result monitor: every strobe is one transfer, checked against the oldest prediction.
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst && strobe !== 1'b0) begin
      if (predicted_events.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("%0t: unexpected result event=%0d id=%0d last=%0d", $realtime,
                   rsp.event_res, rsp.task_ref, rsp.last);
        mismatches++;
      end else begin
        want = predicted_events.pop_front();
        events_checked++;
        if (rsp.event_res === EV_FIRED) fires_seen++;
        if (rsp.event_res === EV_FULL) full_seen++;
        if (rsp.event_res !== want.event_res || rsp.task_ref !== want.task_ref ||
            rsp.last !== want.last) begin
          errors++;
          if (mismatches < 10)
            $display({"%0t: mismatch: expected event=%0d id=%0d last=%0d, ",
                      "got event=%0d id=%0d last=%0d"},
                     $realtime, want.event_res, want.task_ref, want.last,
                     rsp.event_res, rsp.task_ref, rsp.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d requests unsent, %0d results outstanding",
               cycles, timer_reqs.size(), predicted_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [7:0]  task_id;
    logic [1:0]  mode;
    int unsigned pick;

    // Directed: field extremes, re-marking, absent id, marked-but-due, wrap, full table.
    queue_req(MODE_ONCE, 32'd0, 32'd0, 8'd0);
    queue_req(MODE_PERIODIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    queue_req(MODE_DETACH, 32'd0, 32'd0, 8'd0);
    queue_req(MODE_DETACH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    queue_req(MODE_DETACH, 32'd0, 32'd0, 8'h5A);
    queue_req(MODE_TICK, 32'd5, 32'd0, 8'd0);
    queue_req(MODE_TICK, 32'hFFFF_FFFE, 32'd0, 8'd0);
    for (int k = 1; k <= 15; k++)
      queue_req((k % 2) ? MODE_ONCE : MODE_PERIODIC, 32'd100, 32'(k * 10), 8'(k % 8));
    queue_req(MODE_ONCE, 32'd150, 32'd1, 8'hAA);
    queue_req(MODE_PERIODIC, 32'd150, 32'd1, 8'h55);
    queue_req(MODE_DETACH, 32'd150, 32'd0, 8'd3);
    queue_req(MODE_TICK, 32'd200, 32'd0, 8'd0);

    // Random: a running millisecond clock that crosses the wrap point, a small id pool
    // so detaches usually hit, and occasional jumps and out-of-order timestamps.
    clock_ms = 32'hFFFF_FE00;
    repeat (420) begin
      pick = $urandom_range(0, 99);
      clock_ms += 32'($urandom_range(0, 25));
      if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
      now_ms = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_ms;
      task_id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
      case ($urandom_range(0, 9))
        0:       interval_ms = 32'd0;
        1:       interval_ms = $urandom;
        2:       interval_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        default: interval_ms = 32'($urandom_range(1, 60));
      endcase
      if (pick < 35)      mode = MODE_TICK;
      else if (pick < 55) mode = MODE_ONCE;
      else if (pick < 75) mode = MODE_PERIODIC;
      else                mode = MODE_DETACH;
      queue_req(mode, now_ms, interval_ms, task_id);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (timer_reqs.size() != 0 || start) @(posedge clk);
    while (predicted_events.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (predicted_events.size() != 0) begin
      $display("%0d predicted results never arrived", predicted_events.size());
      errors += predicted_events.size();
    end

    $display("requests: %0d tick, %0d one-shot attach, %0d periodic attach, %0d detach",
             reqs_sent[MODE_TICK], reqs_sent[MODE_ONCE], reqs_sent[MODE_PERIODIC],
             reqs_sent[MODE_DETACH]);
    $display("results checked: %0d (%0d fires, %0d full-table refusals), %0d errors",
             events_checked, fires_seen, full_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/swtmr_pkg.sv
rtl/core/swtmr_ctrl.sv
rtl/core/swtmr_dp.sv
rtl/core/software_timer_task_table.sv
rtl/core/swtmr_chk.sv
sim/tb.sv
